### rtl/core/multi_led_blink_controller_defines.svh
// ----------------------------------------------------------------------------
// Multi-LED blink controller assertion macros
// Shared concurrent assertion wrappers for the blink controller RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH
`define MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define MLBC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define MLBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/mlbc_pkg.sv
// ----------------------------------------------------------------------------
// Multi-LED blink controller package
// Types, codes and constants shared by the blink controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mlbc_pkg;

  // Number of LEDs kept by the controller.
  localparam int LED_COUNT = 3;
  // Width of the reported level vector.
  localparam int LEVELS_W  = 3;
  // Field widths.
  localparam int TIME_W    = 32;
  localparam int HALF_W    = 24;
  localparam int INDEX_W   = 2;

  // Reset values of the half periods, in microseconds.
  localparam logic [HALF_W-1:0] SLOW_HALF_RESET = 24'd400000;
  localparam logic [HALF_W-1:0] FAST_HALF_RESET = 24'd150000;

  // LED modes.
  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SLOW = 2'd2,
    MODE_FAST = 2'd3
  } mode_e;

  // Item kinds.
  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_SET  = 1'b1
  } action_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_SLOW_HALF = 1'b0,
    REG_FAST_HALF = 1'b1
  } reg_index_e;

  // Control bundle broadcast to every LED slice.
  typedef struct packed {
    logic              tick;
    logic [TIME_W-1:0] now;
    mode_e             mode;
    logic [HALF_W-1:0] slow_half;
    logic [HALF_W-1:0] fast_half;
  } mlbc_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/multi_led_blink_controller.sv
// An accepted item waits in the input register and shows its levels on the
// output when the result register loads them.
// Throughput: one item per clock while the output is not stalled; the input register
// and the result register form a two-stage pipe, and stage one updates all LED slices.
// Reset: all LEDs go to mode off, level low and time zero; the half periods
// return to 400000 us and 150000 us, and both pipeline stages are emptied.
// ----------------------------------------------------------------------------
// Multi-LED blink controller
// Keeps several LEDs in off, on, slow blink or fast blink and reports levels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_led_blink_controller_defines.svh"

module multi_led_blink_controller (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write port.
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_index_i,
  input  wire logic [mlbc_pkg::HALF_W-1:0]  cfg_wdata_i,
  // Input channel.
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         in_action_i,
  input  wire logic [mlbc_pkg::TIME_W-1:0]  in_now_us_i,
  input  wire logic [mlbc_pkg::INDEX_W-1:0] in_led_index_i,
  input  wire logic [1:0]                   in_mode_i,
  // Output channel.
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [mlbc_pkg::LEVELS_W-1:0]     out_led_levels_o
);
  import mlbc_pkg::*;

  logic [HALF_W-1:0]   slow_half_q, fast_half_q;
  logic                s1_valid_q;
  action_e             act_q;
  logic [TIME_W-1:0]   now_q;
  logic [INDEX_W-1:0]  idx_q;
  logic [1:0]          mode_q;
  logic                out_valid_q;
  logic [LEVELS_W-1:0] levels_q, levels_d;
  logic                out_free;
  logic                advance;
  mlbc_ctrl_t          ctrl;
  logic [LED_COUNT-1:0] level_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_half_q <= SLOW_HALF_RESET;
      fast_half_q <= FAST_HALF_RESET;
    end else if (cfg_we_i) begin
      case (reg_index_e'(cfg_index_i))
        REG_SLOW_HALF: slow_half_q <= cfg_wdata_i;
        REG_FAST_HALF: fast_half_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow: stage one moves on when the result register is free or drains.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      act_q  <= action_e'(in_action_i);
      now_q  <= in_now_us_i;
      idx_q  <= in_led_index_i;
      mode_q <= in_mode_i;
    end
  end

  // Control broadcast to the LED slices.
  always_comb begin
    ctrl.tick      = advance && (act_q == ACT_TICK);
    ctrl.now       = now_q;
    ctrl.mode      = mode_e'(mode_q);
    ctrl.slow_half = slow_half_q;
    ctrl.fast_half = fast_half_q;
  end

  // One slice per LED; a set item addresses only its own slice.
  for (genvar k = 0; k < LED_COUNT; k++) begin : g_led
    mlbc_led u_led (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .set_i   (advance && (act_q == ACT_SET) && (32'(idx_q) == k)),
      .level_o (level_d[k])
    );
  end

  // Pack the levels that fit the output field.
  for (genvar b = 0; b < LEVELS_W; b++) begin : g_pack
    if (b < LED_COUNT) begin : g_led_bit
      assign levels_d[b] = level_d[b];
    end else begin : g_zero_bit
      assign levels_d[b] = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      levels_q <= levels_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_led_levels_o = levels_q;

  `MLBC_ASSERT(a_accept_fills_stage, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> s1_valid_q, "Accepted item did not reach the input register")
  `MLBC_ASSERT(a_stage_reaches_output, clk_i, rst_ni, advance |=> out_valid_o, "Stage one moved on but no result is presented")
  `MLBC_ASSERT(a_drain_empties, clk_i, rst_ni, (out_valid_o && !out_stall_i && !s1_valid_q) |=> !out_valid_o, "Result delivered twice")
  `MLBC_ASSERT_ALWAYS(a_reset_empty, clk_i, (!rst_ni && $past(!rst_ni)) |-> (!s1_valid_q && !out_valid_q), "Pipeline not empty during reset")

endmodule

`default_nettype wire

### rtl/core/mlbc_led.sv
// ----------------------------------------------------------------------------
// Multi-LED blink controller LED slice
// Holds the mode, level and last change time of one LED and updates them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_led_blink_controller_defines.svh"

module mlbc_led (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mlbc_pkg::mlbc_ctrl_t ctrl_i,
  input  wire logic                set_i,
  output logic                     level_o
);
  import mlbc_pkg::*;

  mode_e             mode_q, mode_d;
  logic              level_q, level_d;
  logic [TIME_W-1:0] stamp_q, stamp_d;
  logic [HALF_W-1:0] half;
  logic [TIME_W-1:0] elapsed;

  // Half period of the current blink rate and wrapping elapsed time.
  assign half    = (mode_q == MODE_SLOW) ? ctrl_i.slow_half : ctrl_i.fast_half;
  assign elapsed = ctrl_i.now - stamp_q;

  // Next state for a tick or a mode change.
  always_comb begin
    mode_d  = mode_q;
    level_d = level_q;
    stamp_d = stamp_q;
    if (set_i) begin
      mode_d = ctrl_i.mode;
    end
    if (ctrl_i.tick) begin
      unique case (mode_q)
        MODE_OFF: begin
          level_d = 1'b0;
          stamp_d = ctrl_i.now;
        end
        MODE_ON: begin
          level_d = 1'b1;
          stamp_d = ctrl_i.now;
        end
        default: begin
          if (elapsed > TIME_W'(half)) begin
            level_d = ~level_q;
            stamp_d = ctrl_i.now;
          end
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      level_q <= 1'b0;
      stamp_q <= '0;
    end else begin
      mode_q  <= mode_d;
      level_q <= level_d;
      stamp_q <= stamp_d;
    end
  end

  // The result register takes the updated level.
  assign level_o = level_d;

  `MLBC_ASSERT(a_on_drives_high, clk_i, rst_ni, (ctrl_i.tick && mode_q == MODE_ON) |=> level_q, "LED in mode on is not high after a tick")
  `MLBC_ASSERT(a_off_drives_low, clk_i, rst_ni, (ctrl_i.tick && mode_q == MODE_OFF) |=> !level_q, "LED in mode off is not low after a tick")
  `MLBC_ASSERT(a_level_stamp, clk_i, rst_ni, (level_q != $past(level_q)) |-> (stamp_q == $past(ctrl_i.now)), "LED level changed without recording the tick time")

endmodule

`default_nettype wire
